// ----- src/svm_pkg.sv -----
// Shared types, constants and helper functions of the sample voice mixer.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package svm_pkg;

    localparam int SAMPLE_DEPTH  = 65536;
    localparam int SAMPLE_AW     = $clog2(SAMPLE_DEPTH);
    localparam int SAMPLE_W      = 8;
    localparam int FRACTION_BITS = 12;
    localparam int POS_W         = 32;
    localparam int INDEX_W       = POS_W - FRACTION_BITS;
    localparam int START_SHIFT   = 8 + FRACTION_BITS;
    localparam int PADDR_W       = 4;
    localparam int PDATA_W       = 32;

    localparam logic [7:0] MIX_VOLUME_RESET = 8'd64;
    localparam logic [9:0] PAN_FULL         = 10'd256;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_START  = 2'd1,
        OP_RENDER = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        REG_LOOP_END    = 2'd0,
        REG_LOOP_LENGTH = 2'd1,
        REG_LOOP_ENABLE = 2'd2,
        REG_MIX_VOLUME  = 2'd3
    } reg_index_t;

    typedef struct packed {
        opcode_t            opcode;
        logic [15:0]        sample_address;
        logic signed [7:0]  sample_byte;
        logic [7:0]         start_offset;
        logic [19:0]        step;
        logic [8:0]         channel_volume;
        logic [8:0]         pan;
        logic signed [15:0] right_in;
        logic signed [15:0] left_in;
    } in_t;

    typedef struct packed {
        logic signed [15:0] right_out;
        logic signed [15:0] left_out;
        logic               voice_active;
    } out_t;

    typedef struct packed {
        logic [15:0] loop_end;
        logic [15:0] loop_length;
        logic        loop_enable;
        logic [7:0]  mix_volume;
    } cfg_t;

    typedef struct packed {
        logic                 en;
        logic                 we;
        logic [SAMPLE_AW-1:0] addr;
        logic [SAMPLE_W-1:0]  wdata;
    } ram_req_t;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/svm_sample_ram.sv -----
// Single-port synchronous sample memory with a registered read port.
// Depends on svm_pkg for the depth, address width and request struct.
`default_nettype none

module svm_sample_ram (
    input  wire logic                        aclk,
    input  wire svm_pkg::ram_req_t           req,
    output logic [svm_pkg::SAMPLE_W-1:0]     rdata
);

    logic [svm_pkg::SAMPLE_W-1:0] sample_mem [svm_pkg::SAMPLE_DEPTH];
    logic [svm_pkg::SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.en) begin
            if (req.we) begin
                sample_mem[req.addr] <= req.wdata;
            end else begin
                rdata_reg <= sample_mem[req.addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/svm_regs.sv -----
// APB configuration registers: loop end, loop length, loop enable, mix volume.
// Depends on svm_pkg for the register map and the configuration struct.
`default_nettype none

module svm_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [svm_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [svm_pkg::PDATA_W-1:0]   pwdata,
    output logic [svm_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready,
    output svm_pkg::cfg_t                      cfg
);

    svm_pkg::cfg_t        cfg_reg;
    svm_pkg::reg_index_t  reg_sel;
    logic                 wr_en;

    assign reg_sel = svm_pkg::reg_index_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.loop_end    <= '0;
            cfg_reg.loop_length <= '0;
            cfg_reg.loop_enable <= 1'b0;
            cfg_reg.mix_volume  <= svm_pkg::MIX_VOLUME_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                svm_pkg::REG_LOOP_END:    cfg_reg.loop_end    <= pwdata[15:0];
                svm_pkg::REG_LOOP_LENGTH: cfg_reg.loop_length <= pwdata[15:0];
                svm_pkg::REG_LOOP_ENABLE: cfg_reg.loop_enable <= pwdata[0];
                svm_pkg::REG_MIX_VOLUME:  cfg_reg.mix_volume  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            svm_pkg::REG_LOOP_END:    prdata = {16'd0, cfg_reg.loop_end};
            svm_pkg::REG_LOOP_LENGTH: prdata = {16'd0, cfg_reg.loop_length};
            svm_pkg::REG_LOOP_ENABLE: prdata = {31'd0, cfg_reg.loop_enable};
            svm_pkg::REG_MIX_VOLUME:  prdata = {24'd0, cfg_reg.mix_volume};
            default:                  prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- src/svm_voice.sv -----
// Voice sequencer: play position, loop handling, gain and pan pipeline, result register.
// Depends on svm_pkg; drives the sample memory through a request struct.
`default_nettype none

module svm_voice (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire svm_pkg::cfg_t                 cfg,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire svm_pkg::in_t                  s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output svm_pkg::out_t                      m_data,
    output svm_pkg::ram_req_t                  ram_req,
    input  wire logic [svm_pkg::SAMPLE_W-1:0]  ram_rdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_SUM,
        ST_DONE
    } state_t;

    state_t                          state_reg;
    svm_pkg::in_t                    item_reg;
    logic [svm_pkg::POS_W-1:0]       pos_reg;
    logic                            voice_on_reg;
    logic                            wrapped_reg;
    logic                            in_range_reg;
    logic signed [16:0]              p1_reg;
    logic signed [14:0]              d_reg;
    logic signed [16:0]              pr_reg;
    logic signed [16:0]              pl_reg;
    logic                            m_valid_reg;
    svm_pkg::out_t                   m_data_reg;

    logic [svm_pkg::INDEX_W-1:0]     idx;
    logic                            past_end;
    logic [svm_pkg::POS_W-1:0]       wrap_pos;
    logic                            idx_in_store;
    logic                            wr_in_store;
    logic signed [7:0]               sample_s;
    logic signed [8:0]               mix_s;
    logic signed [9:0]               vol_s;
    logic signed [9:0]               pan_s;
    logic signed [9:0]               pan_r_s;
    logic signed [16:0]              prod0;
    logic signed [26:0]              prod1;
    logic signed [24:0]              prod_r;
    logic signed [24:0]              prod_l;
    logic signed [17:0]              sum_r;
    logic signed [17:0]              sum_l;
    logic                            out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    assign idx          = pos_reg[svm_pkg::POS_W-1:svm_pkg::FRACTION_BITS];
    assign past_end     = idx >= svm_pkg::INDEX_W'(cfg.loop_end);
    assign wrap_pos     = pos_reg - (svm_pkg::POS_W'(cfg.loop_length) << svm_pkg::FRACTION_BITS);
    assign idx_in_store = svm_pkg::POS_W'(idx) < svm_pkg::POS_W'(svm_pkg::SAMPLE_DEPTH);
    assign wr_in_store  = svm_pkg::POS_W'(s_data.sample_address)
                          < svm_pkg::POS_W'(svm_pkg::SAMPLE_DEPTH);

    always_comb begin
        ram_req.we    = (state_reg == ST_IDLE);
        ram_req.wdata = s_data.sample_byte;
        if (state_reg == ST_IDLE) begin
            ram_req.en   = s_valid && (s_data.opcode == svm_pkg::OP_LOAD) && wr_in_store;
            ram_req.addr = s_data.sample_address[svm_pkg::SAMPLE_AW-1:0];
        end else begin
            ram_req.en   = (state_reg == ST_CHECK) && !past_end && idx_in_store;
            ram_req.addr = idx[svm_pkg::SAMPLE_AW-1:0];
        end
    end

    assign sample_s = in_range_reg ? $signed(ram_rdata) : 8'sd0;
    assign mix_s    = $signed({1'b0, cfg.mix_volume});
    assign vol_s    = $signed({1'b0, item_reg.channel_volume});
    assign pan_s    = $signed({1'b0, item_reg.pan});
    assign pan_r_s  = $signed(svm_pkg::PAN_FULL - {1'b0, item_reg.pan});
    assign prod0    = sample_s * mix_s;
    assign prod1    = p1_reg * vol_s;
    assign prod_r   = d_reg * pan_r_s;
    assign prod_l   = d_reg * pan_s;
    assign sum_r    = 18'(item_reg.right_in) + 18'(pr_reg);
    assign sum_l    = 18'(item_reg.left_in) + 18'(pl_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            voice_on_reg <= 1'b0;
            wrapped_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        item_reg    <= s_data;
                        wrapped_reg <= 1'b0;
                        case (s_data.opcode)
                            svm_pkg::OP_START: begin
                                pos_reg <= svm_pkg::POS_W'(s_data.start_offset)
                                           << svm_pkg::START_SHIFT;
                                voice_on_reg <= 1'b1;
                                state_reg    <= ST_DONE;
                            end
                            svm_pkg::OP_RENDER: begin
                                state_reg <= voice_on_reg ? ST_CHECK : ST_DONE;
                            end
                            default: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_CHECK: begin
                    if (past_end) begin
                        if (cfg.loop_enable && !wrapped_reg) begin
                            pos_reg     <= wrap_pos;
                            wrapped_reg <= 1'b1;
                        end else begin
                            voice_on_reg <= 1'b0;
                            state_reg    <= ST_DONE;
                        end
                    end else begin
                        in_range_reg <= idx_in_store;
                        state_reg    <= ST_MUL0;
                    end
                end
                ST_MUL0: begin
                    p1_reg    <= prod0;
                    pos_reg   <= pos_reg + svm_pkg::POS_W'(item_reg.step);
                    state_reg <= ST_MUL1;
                end
                ST_MUL1: begin
                    d_reg     <= prod1[26:12];
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    pr_reg    <= prod_r[24:8];
                    pl_reg    <= prod_l[24:8];
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    item_reg.right_in <= svm_pkg::sat16(sum_r);
                    item_reg.left_in  <= svm_pkg::sat16(sum_l);
                    state_reg         <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_data_reg.right_out    <= item_reg.right_in;
                        m_data_reg.left_out     <= item_reg.left_in;
                        m_data_reg.voice_active <= voice_on_reg;
                        m_valid_reg             <= 1'b1;
                        state_reg               <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ----- src/sample_voice_mixer.sv -----
// Channel       Ports                                      Moves
// input         s_valid, s_ready, s_data (svm_pkg::in_t)   one command or frame beat
// result        m_valid, m_ready, m_data (svm_pkg::out_t)  one mixed frame beat
// config        psel, penable, pwrite, paddr, pwdata ...   APB register access
//
// One beat is worked on at a time; the result register lets the next beat in while the
// last result still waits. Load, start and idle beats and renders of a stopped voice go
// straight to the result state. A render checks the position, which may stop the voice
// or wrap once, then passes the sample memory read, three multiply stages and a sum.
// Reset is synchronous and clears position, voice flag and registers; the sample memory
// is not cleared. A stalled result holds the block in its final state.
`default_nettype none

module sample_voice_mixer (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire svm_pkg::in_t                  s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output svm_pkg::out_t                      m_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [svm_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [svm_pkg::PDATA_W-1:0]   pwdata,
    output logic [svm_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    svm_pkg::cfg_t                  cfg;
    svm_pkg::ram_req_t              ram_req;
    logic [svm_pkg::SAMPLE_W-1:0]   ram_rdata;

    svm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    svm_sample_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    svm_voice u_voice (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// ----- src/svm_checker.sv -----
// Port-level checks of the sample voice mixer, bound to the top level.
// Depends on svm_pkg for the beat types and on sample_voice_mixer's ports.
`default_nettype none

module svm_port_checks (
    input wire logic            aclk,
    input wire logic            aresetn,
    input wire logic            s_valid,
    input wire logic            s_ready,
    input wire logic            m_valid,
    input wire logic            m_ready,
    input wire svm_pkg::out_t   m_data
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    always_comb begin
        pending_next = pending_reg;
        if (s_valid && s_ready) begin
            pending_next = pending_next + 2'd1;
        end
        if (m_valid && m_ready) begin
            pending_next = pending_next - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat taken while one is in work");

    a_no_invented_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 2'd0)
        else $error("result without an accepted beat");

    a_accept_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> pending_reg == 2'd0 || pending_reg == 2'd1)
        else $error("beat accepted with two results outstanding");

endmodule

bind sample_voice_mixer svm_port_checks u_port_checks (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
